[rtl/tci_pkg.sv]
// Shared types, constants and thrust curve tables for the thrust curve interpolator.
package tci_pkg;

    localparam int TIME_W   = 22;
    localparam int THRUST_W = 21;
    localparam int STAGE_W  = 2;
    localparam int ROM_ROWS = 64;
    localparam int IDX_W    = 6;
    localparam int QUO_W    = THRUST_W;
    localparam int PROD_W   = TIME_W + THRUST_W;

    localparam int BOOSTER_POINTS   = 39;
    localparam int SUSTAINER_POINTS = 21;

    localparam int BOOST_N = (BOOSTER_POINTS < 2) ? 2 :
                             (BOOSTER_POINTS > ROM_ROWS) ? ROM_ROWS : BOOSTER_POINTS;
    localparam int SUST_N  = (SUSTAINER_POINTS < 2) ? 2 :
                             (SUSTAINER_POINTS > ROM_ROWS) ? ROM_ROWS : SUSTAINER_POINTS;
    localparam logic [IDX_W-1:0] BOOST_LAST = IDX_W'(BOOST_N - 1);
    localparam logic [IDX_W-1:0] SUST_LAST  = IDX_W'(SUST_N - 1);

    localparam logic [STAGE_W-1:0] STAGE_BOOST = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_SUST  = 2'd2;

    typedef enum logic [1:0] {
        REGION_NONE    = 2'd0,
        REGION_BEFORE  = 2'd1,
        REGION_INTERP  = 2'd2,
        REGION_BURNOUT = 2'd3
    } region_t;

    // Segment endpoints handed from the search to the arithmetic
    typedef struct packed {
        logic [TIME_W-1:0]   t;
        logic [TIME_W-1:0]   x0;
        logic [TIME_W-1:0]   x1;
        logic [THRUST_W-1:0] y0;
        logic [THRUST_W-1:0] y1;
        region_t             region;
    } seg_t;

    // Sideband carried alongside the divider
    typedef struct packed {
        region_t             region;
        logic [THRUST_W-1:0] base;
        logic                neg;
        logic                use_q;
    } side_t;

    localparam logic [TIME_W-1:0] BOOST_T [ROM_ROWS] = '{
        0:22'd2884, 1:22'd4129, 2:22'd5112, 3:22'd6160, 4:22'd7143, 5:22'd8192,
        6:22'd9634, 7:22'd12714, 8:22'd22938, 9:22'd28049, 10:22'd36897,
        11:22'd45482, 12:22'd64750, 13:22'd82969, 14:22'd97714, 15:22'd103612,
        16:22'd107545, 17:22'd110363, 18:22'd112460, 19:22'd116916, 20:22'd127009,
        21:22'd140116, 22:22'd163250, 23:22'd170394, 24:22'd191300, 25:22'd198050,
        26:22'd205652, 27:22'd216269, 28:22'd222036, 29:22'd225509, 30:22'd232260,
        31:22'd236519, 32:22'd241697, 33:22'd247595, 34:22'd250282, 35:22'd252510,
        36:22'd255394, 37:22'd260899, 38:22'd261947, default:22'd0
    };
    localparam logic [THRUST_W-1:0] BOOST_F [ROM_ROWS] = '{
        0:21'd1820735, 1:21'd1724082, 2:21'd1765878, 3:21'd1692735, 4:21'd1731918,
        5:21'd1674449, 6:21'd1684898, 7:21'd1669224, 8:21'd1739755, 9:21'd1815510,
        10:21'd1865143, 11:21'd1896490, 12:21'd1940898, 13:21'd1951347,
        14:21'd1977469, 15:21'd1959184, 16:21'd1930449, 17:21'd1920000,
        18:21'd1878204, 19:21'd1849469, 20:21'd1737143, 21:21'd1619592,
        22:21'd1509878, 23:21'd1460245, 24:21'd906449, 25:21'd872490, 26:21'd739265,
        27:21'd572082, 28:21'd428408, 29:21'd381388, 30:21'd363102, 31:21'd331755,
        32:21'd208980, 33:21'd167184, 34:21'd148898, 35:21'd125388, 36:21'd73143,
        37:21'd5224, 38:21'd0, default:21'd0
    };
    localparam logic [TIME_W-1:0] SUST_T [ROM_ROWS] = '{
        0:22'd8520, 1:22'd16318, 2:22'd20185, 3:22'd26411, 4:22'd44237, 5:22'd66716,
        6:22'd95420, 7:22'd129565, 8:22'd196280, 9:22'd261489, 10:22'd326697,
        11:22'd360055, 12:22'd392626, 13:22'd475660, 14:22'd515244, 15:22'd525271,
        16:22'd589693, 17:22'd654901, 18:22'd689046, 19:22'd753402, 20:22'd786039,
        default:22'd0
    };
    localparam logic [THRUST_W-1:0] SUST_F [ROM_ROWS] = '{
        0:21'd350304, 1:21'd348517, 2:21'd353283, 3:21'd347921, 4:21'd303240,
        5:21'd274643, 6:21'd254983, 7:21'd245451, 8:21'd234132, 9:21'd219238,
        10:21'd200174, 11:21'd187067, 12:21'd173961, 13:21'd138811, 14:21'd118555,
        15:21'd116768, 16:21'd84597, 17:21'd53022, 18:21'd35150, 19:21'd8936,
        20:21'd0, default:21'd0
    };

    function automatic logic [TIME_W-1:0] rom_time(input logic boost,
                                                  input logic [IDX_W-1:0] idx);
        rom_time = boost ? BOOST_T[idx] : SUST_T[idx];
    endfunction

    function automatic logic [THRUST_W-1:0] rom_thrust(input logic boost,
                                                      input logic [IDX_W-1:0] idx);
        rom_thrust = boost ? BOOST_F[idx] : SUST_F[idx];
    endfunction

endpackage

[rtl/tci_search.sv]
// Two-stage breakpoint search: comparator bank, then priority encode and ROM fetch.
module tci_search (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  logic [tci_pkg::TIME_W-1:0] t_in,
    input  logic [tci_pkg::STAGE_W-1:0] stage_in,
    output logic                       valid_out,
    output tci_pkg::seg_t              seg_out
);
    import tci_pkg::*;

    logic                  s1_valid_reg;
    logic [TIME_W-1:0]     s1_t_reg;
    logic                  s1_boost_reg;
    region_t               s1_region_reg;
    logic [ROM_ROWS-1:0]   s1_cmp_reg;

    logic                  boost;
    logic [IDX_W-1:0]      last;
    region_t               region_next;
    logic [ROM_ROWS-1:0]   cmp_next;

    logic                  s2_valid_reg;
    seg_t                  s2_seg_reg;
    seg_t                  seg_next;
    logic [IDX_W-1:0]      seg_idx;
    logic [IDX_W-1:0]      s1_last;

    always_comb
    begin
        boost = (stage_in == STAGE_BOOST);
        last  = boost ? BOOST_LAST : SUST_LAST;
        cmp_next = '0;
        for (int k = 1; k < ROM_ROWS; k++)
        begin
            if (IDX_W'(k) <= last)
                cmp_next[k] = (rom_time(boost, IDX_W'(k)) >= t_in);
        end
        if (stage_in != STAGE_BOOST && stage_in != STAGE_SUST)
            region_next = REGION_NONE;
        else if (t_in <= rom_time(boost, '0))
            region_next = REGION_BEFORE;
        else if (t_in >= rom_time(boost, last))
            region_next = REGION_BURNOUT;
        else
            region_next = REGION_INTERP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_t_reg      <= t_in;
            s1_boost_reg  <= boost;
            s1_region_reg <= region_next;
            s1_cmp_reg    <= cmp_next;
        end
    end

    // Lowest set compare bit picks segment, else the last; segment 1 if not INTERP
    always_comb
    begin
        s1_last = s1_boost_reg ? BOOST_LAST : SUST_LAST;
        seg_idx = s1_last;
        for (int k = ROM_ROWS - 1; k >= 1; k--)
        begin
            if (s1_cmp_reg[k])
                seg_idx = IDX_W'(k);
        end
        if (s1_region_reg != REGION_INTERP)
            seg_idx = IDX_W'(1);
        seg_next.t      = s1_t_reg;
        seg_next.x0     = rom_time(s1_boost_reg, seg_idx - IDX_W'(1));
        seg_next.x1     = rom_time(s1_boost_reg, seg_idx);
        seg_next.y0     = rom_thrust(s1_boost_reg, seg_idx - IDX_W'(1));
        seg_next.y1     = rom_thrust(s1_boost_reg, seg_idx);
        seg_next.region = s1_region_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_seg_reg <= seg_next;
    end

    assign valid_out = s2_valid_reg;
    assign seg_out   = s2_seg_reg;

endmodule

[rtl/tci_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
module tci_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic [tci_pkg::PROD_W-1:0]  num,
    input  logic [tci_pkg::TIME_W-1:0]  den,
    input  tci_pkg::side_t              side_in,
    output logic                        valid_out,
    output logic [tci_pkg::QUO_W-1:0]   quo,
    output tci_pkg::side_t              side_out
);
    import tci_pkg::*;

    logic               v_reg    [QUO_W];
    logic [PROD_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]   q_reg    [QUO_W];
    logic [TIME_W-1:0]  den_reg  [QUO_W];
    side_t              side_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_step
        logic               v_in;
        logic [PROD_W-1:0]  rem_in;
        logic [QUO_W-1:0]   q_in;
        logic [TIME_W-1:0]  den_in;
        side_t              side_step;
        logic [PROD_W-1:0]  shifted;
        logic               ge;

        if (i == 0)
        begin : g_first
            assign v_in      = valid_in;
            assign rem_in    = num;
            assign q_in      = '0;
            assign den_in    = den;
            assign side_step = side_in;
        end
        else
        begin : g_next
            assign v_in      = v_reg[i-1];
            assign rem_in    = rem_reg[i-1];
            assign q_in      = q_reg[i-1];
            assign den_in    = den_reg[i-1];
            assign side_step = side_reg[i-1];
        end

        assign shifted = PROD_W'(den_in) << (QUO_W - 1 - i);
        assign ge      = (rem_in >= shifted);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? (rem_in - shifted) : rem_in;
                q_reg[i]    <= q_in | (QUO_W'(ge) << (QUO_W - 1 - i));
                den_reg[i]  <= den_in;
                side_reg[i] <= side_step;
            end
        end
    end

    assign valid_out = v_reg[QUO_W-1];
    assign quo       = q_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

[rtl/thrust_curve_interpolator.sv]
// Throughput: one request per cycle; the 21-stage divider and search pipeline all advance
// together and hold in place while the output result waits to be taken.
// Reset: rst_n clears every valid bit asynchronously; data registers are not reset.
// Top level: segment search, delta/multiply stages, divider and output stage.
module thrust_curve_interpolator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tci_pkg::TIME_W-1:0]   elapsed_time,
    input  logic [tci_pkg::STAGE_W-1:0]  motor_stage,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tci_pkg::THRUST_W-1:0] thrust,
    output logic [1:0]                   curve_region
);
    import tci_pkg::*;

    logic                 en;
    logic                 seg_valid;
    seg_t                 seg;

    logic                 s3_valid_reg;
    logic [TIME_W-1:0]    s3_dt_reg;
    logic [TIME_W-1:0]    s3_dx_reg;
    logic [THRUST_W-1:0]  s3_ady_reg;
    side_t                s3_side_reg;
    side_t                side_next;
    logic                 degen;

    logic                 s4_valid_reg;
    logic [PROD_W-1:0]    s4_prod_reg;
    logic [TIME_W-1:0]    s4_dx_reg;
    side_t                s4_side_reg;

    logic                 div_valid;
    logic [QUO_W-1:0]     div_quo;
    side_t                div_side;
    logic [QUO_W-1:0]     q_used;
    logic [THRUST_W+1:0]  sum;
    logic [THRUST_W-1:0]  thrust_next;

    logic                 out_valid_reg;
    logic [THRUST_W-1:0]  thrust_reg;
    region_t              region_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    tci_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .t_in      (elapsed_time),
        .stage_in  (motor_stage),
        .valid_out (seg_valid),
        .seg_out   (seg)
    );

    always_comb
    begin
        degen           = (seg.x1 <= seg.x0);
        side_next.region = seg.region;
        side_next.neg    = (seg.y1 < seg.y0);
        side_next.use_q  = (seg.region == REGION_INTERP) && !degen;
        case (seg.region)
            REGION_BEFORE: side_next.base = seg.y0;
            REGION_INTERP: side_next.base = degen ? seg.y1 : seg.y0;
            default:       side_next.base = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= seg_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dt_reg   <= seg.t - seg.x0;
            s3_dx_reg   <= seg.x1 - seg.x0;
            s3_ady_reg  <= (seg.y1 < seg.y0) ? (seg.y0 - seg.y1) : (seg.y1 - seg.y0);
            s3_side_reg <= side_next;
            // non-interpolated requests feed a zero numerator; quotient is masked anyway
            s4_prod_reg <= s3_side_reg.use_q ? (PROD_W'(s3_dt_reg) * PROD_W'(s3_ady_reg))
                                             : '0;
            s4_dx_reg   <= s3_dx_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    tci_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s4_valid_reg),
        .num       (s4_prod_reg),
        .den       (s4_dx_reg),
        .side_in   (s4_side_reg),
        .valid_out (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    always_comb
    begin
        q_used = div_side.use_q ? div_quo : '0;
        sum = div_side.neg ? ({2'b00, div_side.base} - {2'b00, q_used})
                           : ({2'b00, div_side.base} + {2'b00, q_used});
        if (sum[THRUST_W+1])
            thrust_next = '0;
        else if (sum[THRUST_W])
            thrust_next = '1;
        else
            thrust_next = sum[THRUST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            thrust_reg <= thrust_next;
            region_reg <= div_side.region;
        end
    end

    assign out_valid    = out_valid_reg;
    assign thrust       = thrust_reg;
    assign curve_region = region_reg;

endmodule
